/* rtl/core/psov_pkg.sv */
// ----------------------------------------------------------------------------
// psov_pkg
// Shared widths, constants, register indexes and transaction types for the
// periodic sphere overlap volume pipeline.
// ----------------------------------------------------------------------------
package psov_pkg;

   localparam int FRAC_BITS  = 12;

   localparam int COORD_W    = 22;
   localparam int RAD_W      = 18;
   localparam int BOX_W      = 10;
   localparam int MARGIN_W   = 16;
   localparam int VOL_W      = 33;

   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_BOX_X  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_Y  = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_Z  = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MARGIN = 4'd3;

   localparam logic [BOX_W-1:0]    BOX_RESET    = 10'd64;
   localparam logic [MARGIN_W-1:0] MARGIN_RESET = 16'd1;

   // geometry widths
   localparam int SQ_W      = 2 * COORD_W;
   localparam int DIST2_W   = SQ_W + 2;
   localparam int RSUM_W    = RAD_W + 1;
   localparam int RSQ_W     = 2 * RSUM_W;
   localparam int RDSQ_W    = 2 * RAD_W;

   // square root
   localparam int ROOT_IN_W = RSQ_W;
   localparam int ROOT_W    = RSUM_W;
   localparam int REM_W     = ROOT_W + 2;

   // volume products
   localparam int PI_W      = 32;
   localparam logic [PI_W-1:0] PI_Q30 = 32'd3373259426;
   localparam int X_W       = 2 * ROOT_W;
   localparam int X_SPLIT   = X_W / 2;
   localparam int XH_W      = X_W - X_SPLIT + PI_W;
   localparam int Y_W       = X_W + 2;
   localparam int Y_SPLIT   = Y_W / 2;
   localparam int XP_W      = X_W + PI_W;
   localparam int XP_SPLIT  = XP_W / 2;
   localparam int PP_W      = XP_SPLIT + Y_SPLIT;
   localparam int PSUM_W    = PP_W + Y_SPLIT;
   localparam int PROD_W    = XP_W + Y_W;
   localparam int SCALE_SH  = 2 * FRAC_BITS + 30;
   localparam int NUM_W     = PROD_W - SCALE_SH;
   localparam int DEN_W     = ROOT_W + 4;

   localparam logic [DEN_W-1:0] SPHERE_DEN = 23'd3;
   localparam logic [DEN_W-1:0] LENS_DEN   = 23'd12;

   typedef struct packed {
      logic [COORD_W-1:0] first_x;
      logic [COORD_W-1:0] first_y;
      logic [COORD_W-1:0] first_z;
      logic [RAD_W-1:0]   first_radius;
      logic [COORD_W-1:0] second_x;
      logic [COORD_W-1:0] second_y;
      logic [COORD_W-1:0] second_z;
      logic [RAD_W-1:0]   second_radius;
   } req_type;

   typedef struct packed {
      logic             overlapped;
      logic [VOL_W-1:0] shared_volume;
   } rsp_type;

   typedef struct packed {
      logic              hit;
      logic              contain;
      logic [RSUM_W-1:0] rsum;
      logic [RAD_W-1:0]  rdif;
      logic [RAD_W-1:0]  rmin;
   } side_type;

   typedef struct packed {
      logic [ROOT_IN_W-1:0] dist2;
      side_type             side;
   } root_in_type;

   typedef struct packed {
      logic             hit;
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
   } quo_type;

endpackage

/* rtl/core/psov_geom.sv */
// ----------------------------------------------------------------------------
// psov_geom
// Minimum-image distance, squared distance, overlap and containment tests.
// Three register stages.
// ----------------------------------------------------------------------------
module psov_geom (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_valid,
   input  psov_pkg::req_type             in_data,
   input  logic [psov_pkg::BOX_W-1:0]    box_x,
   input  logic [psov_pkg::BOX_W-1:0]    box_y,
   input  logic [psov_pkg::BOX_W-1:0]    box_z,
   input  logic [psov_pkg::MARGIN_W-1:0] margin,
   output logic                          out_valid,
   output psov_pkg::root_in_type         out_data
);

   function automatic logic [psov_pkg::COORD_W-1:0] axis_offset(
      input logic [psov_pkg::COORD_W-1:0] a,
      input logic [psov_pkg::COORD_W-1:0] b,
      input logic [psov_pkg::BOX_W-1:0]   box
   );
      logic [psov_pkg::COORD_W-1:0] len;
      logic [psov_pkg::COORD_W-1:0] ad;
      logic [psov_pkg::COORD_W-1:0] wrap;
      len  = psov_pkg::COORD_W'(box) << psov_pkg::FRAC_BITS;
      ad   = (a > b) ? a - b : b - a;
      wrap = (len > ad) ? len - ad : ad - len;
      return (ad < wrap) ? ad : wrap;
   endfunction

   // stage 1
   logic                          v1_ff;
   logic [psov_pkg::COORD_W-1:0]  mx_ff, my_ff, mz_ff;
   logic [psov_pkg::RSUM_W-1:0]   rs1_ff, rs1_in;
   logic [psov_pkg::RAD_W-1:0]    rdif1_ff, rdif1_in, rmin1_ff, rmin1_in;
   // stage 2
   logic                          v2_ff;
   logic [psov_pkg::SQ_W-1:0]     sqx_ff, sqy_ff, sqz_ff;
   logic [psov_pkg::RSQ_W-1:0]    rs2sq_ff;
   logic [psov_pkg::RDSQ_W-1:0]   rd2sq_ff;
   logic [psov_pkg::RSUM_W-1:0]   rs2_ff;
   logic [psov_pkg::RAD_W-1:0]    rdif2_ff, rmin2_ff;
   // stage 3
   logic                          v3_ff;
   psov_pkg::root_in_type         out_ff, out_in;
   logic [psov_pkg::DIST2_W-1:0]  dist2;

   always_comb begin
      rs1_in   = psov_pkg::RSUM_W'(in_data.first_radius)
               + psov_pkg::RSUM_W'(in_data.second_radius);
      rdif1_in = (in_data.first_radius > in_data.second_radius)
               ? in_data.first_radius - in_data.second_radius
               : in_data.second_radius - in_data.first_radius;
      rmin1_in = (in_data.first_radius < in_data.second_radius)
               ? in_data.first_radius : in_data.second_radius;
   end

   always_comb begin
      dist2 = psov_pkg::DIST2_W'(sqx_ff) + psov_pkg::DIST2_W'(sqy_ff)
            + psov_pkg::DIST2_W'(sqz_ff);
      out_in.dist2        = dist2[psov_pkg::ROOT_IN_W-1:0];
      out_in.side.hit     = (psov_pkg::DIST2_W+1)'(rs2sq_ff)
                          > (psov_pkg::DIST2_W+1)'(dist2) + (psov_pkg::DIST2_W+1)'(margin);
      out_in.side.contain = dist2 <= psov_pkg::DIST2_W'(rd2sq_ff);
      out_in.side.rsum    = rs2_ff;
      out_in.side.rdif    = rdif2_ff;
      out_in.side.rmin    = rmin2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mx_ff    <= axis_offset(in_data.first_x, in_data.second_x, box_x);
         my_ff    <= axis_offset(in_data.first_y, in_data.second_y, box_y);
         mz_ff    <= axis_offset(in_data.first_z, in_data.second_z, box_z);
         rs1_ff   <= rs1_in;
         rdif1_ff <= rdif1_in;
         rmin1_ff <= rmin1_in;

         sqx_ff   <= psov_pkg::SQ_W'(mx_ff) * psov_pkg::SQ_W'(mx_ff);
         sqy_ff   <= psov_pkg::SQ_W'(my_ff) * psov_pkg::SQ_W'(my_ff);
         sqz_ff   <= psov_pkg::SQ_W'(mz_ff) * psov_pkg::SQ_W'(mz_ff);
         rs2sq_ff <= psov_pkg::RSQ_W'(rs1_ff) * psov_pkg::RSQ_W'(rs1_ff);
         rd2sq_ff <= psov_pkg::RDSQ_W'(rdif1_ff) * psov_pkg::RDSQ_W'(rdif1_ff);
         rs2_ff   <= rs1_ff;
         rdif2_ff <= rdif1_ff;
         rmin2_ff <= rmin1_ff;

         out_ff   <= out_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_data  = out_ff;

endmodule

/* rtl/core/psov_sqrt.sv */
// ----------------------------------------------------------------------------
// psov_sqrt
// Pipelined integer square root, one result bit per register stage.
// ----------------------------------------------------------------------------
module psov_sqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        adv,
   input  logic                        in_valid,
   input  psov_pkg::root_in_type       in_data,
   output logic                        out_valid,
   output logic [psov_pkg::ROOT_W-1:0] out_root,
   output psov_pkg::side_type          out_side
);

   logic [psov_pkg::REM_W-1:0]     rem_w  [psov_pkg::ROOT_W+1];
   logic [psov_pkg::ROOT_W-1:0]    root_w [psov_pkg::ROOT_W+1];
   logic [psov_pkg::ROOT_IN_W-1:0] rest_w [psov_pkg::ROOT_W+1];
   psov_pkg::side_type             side_w [psov_pkg::ROOT_W+1];
   logic [psov_pkg::ROOT_W:0]      v_w;

   assign rem_w[0]  = '0;
   assign root_w[0] = '0;
   assign rest_w[0] = in_data.dist2;
   assign side_w[0] = in_data.side;
   assign v_w[0]    = in_valid;

   for (genvar s = 0; s < psov_pkg::ROOT_W; s++) begin : g_step
      logic                           v_ff;
      logic [psov_pkg::REM_W-1:0]     rem_ff, rem_in;
      logic [psov_pkg::ROOT_W-1:0]    root_ff, root_in;
      logic [psov_pkg::ROOT_IN_W-1:0] rest_ff, rest_in;
      psov_pkg::side_type             side_ff;
      logic [psov_pkg::REM_W+1:0]     cur;
      logic [psov_pkg::REM_W+1:0]     trial;

      always_comb begin
         // bring down the next two bits and try root*4+1
         cur     = {rem_w[s], rest_w[s][psov_pkg::ROOT_IN_W-1 -: 2]};
         trial   = (psov_pkg::REM_W+2)'({root_w[s], 2'b01});
         rest_in = rest_w[s] << 2;
         if (cur >= trial) begin
            rem_in  = psov_pkg::REM_W'(cur - trial);
            root_in = {root_w[s][psov_pkg::ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = cur[psov_pkg::REM_W-1:0];
            root_in = {root_w[s][psov_pkg::ROOT_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff <= 1'b0;
         end else if (adv) begin
            v_ff <= v_w[s];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff  <= rem_in;
            root_ff <= root_in;
            rest_ff <= rest_in;
            side_ff <= side_w[s];
         end
      end

      assign v_w[s+1]    = v_ff;
      assign rem_w[s+1]  = rem_ff;
      assign root_w[s+1] = root_ff;
      assign rest_w[s+1] = rest_ff;
      assign side_w[s+1] = side_ff;
   end

   assign out_valid = v_w[psov_pkg::ROOT_W];
   assign out_root  = root_w[psov_pkg::ROOT_W];
   assign out_side  = side_w[psov_pkg::ROOT_W];

endmodule

/* rtl/core/psov_vol.sv */
// ----------------------------------------------------------------------------
// psov_vol
// Lens or sphere volume numerator times pi, scaled down, and the divisor.
// Seven register stages; wide products are split into partial products.
// ----------------------------------------------------------------------------
module psov_vol (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        adv,
   input  logic                        in_valid,
   input  logic [psov_pkg::ROOT_W-1:0] in_root,
   input  psov_pkg::side_type          in_side,
   output logic                        out_valid,
   output psov_pkg::quo_type           out_data
);

   logic [6:0] v_ff;
   logic [6:0] hit_ff;

   // stage 1
   logic [psov_pkg::RSQ_W-1:0]  dd1_ff, dr1_ff;
   logic [psov_pkg::RDSQ_W-1:0] rr1_ff, rm1_ff;
   logic [psov_pkg::ROOT_W-1:0] a1_ff, d1_ff;
   logic [psov_pkg::RAD_W-1:0]  rmin1_ff;
   logic                        cont1_ff;
   // stage 2
   logic [psov_pkg::Y_W-1:0]    pos, neg, lens_b;
   logic [psov_pkg::X_W-1:0]    a_sq;
   logic [psov_pkg::X_W-1:0]    x2_ff, x2_in;
   logic [psov_pkg::Y_W-1:0]    y2_ff, y2_in;
   logic [psov_pkg::DEN_W-1:0]  den2_ff, den2_in;
   // stage 3
   logic [psov_pkg::XH_W-1:0]   xh3_ff, xl3_ff;
   logic [psov_pkg::Y_W-1:0]    y3_ff;
   logic [psov_pkg::DEN_W-1:0]  den3_ff;
   // stage 4
   logic [psov_pkg::XP_W-1:0]   xp4_ff;
   logic [psov_pkg::Y_W-1:0]    y4_ff;
   logic [psov_pkg::DEN_W-1:0]  den4_ff;
   // stage 5
   logic [psov_pkg::PP_W-1:0]   pll5_ff, plh5_ff, phl5_ff, phh5_ff;
   logic [psov_pkg::DEN_W-1:0]  den5_ff;
   // stage 6
   logic [psov_pkg::PSUM_W-1:0] slo6_ff, shi6_ff;
   logic [psov_pkg::DEN_W-1:0]  den6_ff;
   // stage 7
   logic [psov_pkg::PROD_W-1:0] prod;
   psov_pkg::quo_type           out_ff, out_in;

   always_comb begin
      pos    = psov_pkg::Y_W'(dd1_ff) + (psov_pkg::Y_W'(dr1_ff) << 1);
      neg    = psov_pkg::Y_W'(rr1_ff) + (psov_pkg::Y_W'(rr1_ff) << 1);
      lens_b = (pos > neg) ? pos - neg : '0;
      a_sq   = psov_pkg::X_W'(a1_ff) * psov_pkg::X_W'(a1_ff);
      if (cont1_ff) begin
         // smaller sphere: rmin^2 * 4*rmin / 3
         x2_in   = psov_pkg::X_W'(rm1_ff);
         y2_in   = psov_pkg::Y_W'(rmin1_ff) << 2;
         den2_in = psov_pkg::SPHERE_DEN;
      end else begin
         x2_in   = a_sq;
         y2_in   = lens_b;
         den2_in = psov_pkg::DEN_W'(d1_ff) * psov_pkg::LENS_DEN;
      end
   end

   always_comb begin
      prod = psov_pkg::PROD_W'(slo6_ff)
           + (psov_pkg::PROD_W'(shi6_ff) << psov_pkg::XP_SPLIT);
      out_in.hit = hit_ff[5];
      out_in.num = prod[psov_pkg::PROD_W-1 -: psov_pkg::NUM_W];
      out_in.den = den6_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[5:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         hit_ff   <= {hit_ff[5:0], in_side.hit};

         dd1_ff   <= psov_pkg::RSQ_W'(in_root) * psov_pkg::RSQ_W'(in_root);
         dr1_ff   <= psov_pkg::RSQ_W'(in_root) * psov_pkg::RSQ_W'(in_side.rsum);
         rr1_ff   <= psov_pkg::RDSQ_W'(in_side.rdif) * psov_pkg::RDSQ_W'(in_side.rdif);
         rm1_ff   <= psov_pkg::RDSQ_W'(in_side.rmin) * psov_pkg::RDSQ_W'(in_side.rmin);
         a1_ff    <= (in_side.rsum > in_root) ? in_side.rsum - in_root : '0;
         d1_ff    <= in_root;
         rmin1_ff <= in_side.rmin;
         cont1_ff <= in_side.contain;

         x2_ff    <= x2_in;
         y2_ff    <= y2_in;
         den2_ff  <= den2_in;

         xh3_ff   <= psov_pkg::XH_W'(x2_ff[psov_pkg::X_W-1:psov_pkg::X_SPLIT])
                   * psov_pkg::XH_W'(psov_pkg::PI_Q30);
         xl3_ff   <= psov_pkg::XH_W'(x2_ff[psov_pkg::X_SPLIT-1:0])
                   * psov_pkg::XH_W'(psov_pkg::PI_Q30);
         y3_ff    <= y2_ff;
         den3_ff  <= den2_ff;

         xp4_ff   <= (psov_pkg::XP_W'(xh3_ff) << psov_pkg::X_SPLIT)
                   + psov_pkg::XP_W'(xl3_ff);
         y4_ff    <= y3_ff;
         den4_ff  <= den3_ff;

         pll5_ff  <= psov_pkg::PP_W'(xp4_ff[psov_pkg::XP_SPLIT-1:0])
                   * psov_pkg::PP_W'(y4_ff[psov_pkg::Y_SPLIT-1:0]);
         plh5_ff  <= psov_pkg::PP_W'(xp4_ff[psov_pkg::XP_SPLIT-1:0])
                   * psov_pkg::PP_W'(y4_ff[psov_pkg::Y_W-1:psov_pkg::Y_SPLIT]);
         phl5_ff  <= psov_pkg::PP_W'(xp4_ff[psov_pkg::XP_W-1:psov_pkg::XP_SPLIT])
                   * psov_pkg::PP_W'(y4_ff[psov_pkg::Y_SPLIT-1:0]);
         phh5_ff  <= psov_pkg::PP_W'(xp4_ff[psov_pkg::XP_W-1:psov_pkg::XP_SPLIT])
                   * psov_pkg::PP_W'(y4_ff[psov_pkg::Y_W-1:psov_pkg::Y_SPLIT]);
         den5_ff  <= den4_ff;

         slo6_ff  <= psov_pkg::PSUM_W'(pll5_ff)
                   + (psov_pkg::PSUM_W'(plh5_ff) << psov_pkg::Y_SPLIT);
         shi6_ff  <= psov_pkg::PSUM_W'(phl5_ff)
                   + (psov_pkg::PSUM_W'(phh5_ff) << psov_pkg::Y_SPLIT);
         den6_ff  <= den5_ff;

         out_ff   <= out_in;
      end
   end

   assign out_valid = v_ff[6];
   assign out_data  = out_ff;

endmodule

/* rtl/core/psov_div.sv */
// ----------------------------------------------------------------------------
// psov_div
// Pipelined restoring divider with saturation, one quotient bit per stage.
// ----------------------------------------------------------------------------
module psov_div (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  psov_pkg::quo_type in_data,
   output logic              out_valid,
   output psov_pkg::rsp_type out_data
);

   localparam int HI_W = psov_pkg::NUM_W - psov_pkg::VOL_W;

   logic [psov_pkg::DEN_W-1:0] rem_w  [psov_pkg::VOL_W+1];
   logic [psov_pkg::VOL_W-1:0] low_w  [psov_pkg::VOL_W+1];
   logic [psov_pkg::VOL_W-1:0] quo_w  [psov_pkg::VOL_W+1];
   logic [psov_pkg::DEN_W-1:0] den_w  [psov_pkg::VOL_W+1];
   logic [psov_pkg::VOL_W:0]   sat_w;
   logic [psov_pkg::VOL_W:0]   hit_w;
   logic [psov_pkg::VOL_W:0]   v_w;

   // front stage: overflow check, top bits seed the remainder
   logic                       v0_ff, sat0_ff, hit0_ff;
   logic [psov_pkg::DEN_W-1:0] rem0_ff, den0_ff;
   logic [psov_pkg::VOL_W-1:0] low0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (adv) begin
         v0_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sat0_ff <= psov_pkg::DEN_W'(in_data.num[psov_pkg::NUM_W-1 -: HI_W]) >= in_data.den;
         rem0_ff <= psov_pkg::DEN_W'(in_data.num[psov_pkg::NUM_W-1 -: HI_W]);
         low0_ff <= in_data.num[psov_pkg::VOL_W-1:0];
         den0_ff <= in_data.den;
         hit0_ff <= in_data.hit;
      end
   end

   assign rem_w[0] = rem0_ff;
   assign low_w[0] = low0_ff;
   assign quo_w[0] = '0;
   assign den_w[0] = den0_ff;
   assign sat_w[0] = sat0_ff;
   assign hit_w[0] = hit0_ff;
   assign v_w[0]   = v0_ff;

   for (genvar s = 0; s < psov_pkg::VOL_W; s++) begin : g_step
      logic                       v_ff, sat_ff, hit_ff;
      logic [psov_pkg::DEN_W-1:0] rem_ff, rem_in, den_ff;
      logic [psov_pkg::VOL_W-1:0] low_ff, quo_ff, quo_in;
      logic [psov_pkg::DEN_W:0]   cur;

      always_comb begin
         cur = {rem_w[s], low_w[s][psov_pkg::VOL_W-1]};
         if (cur >= {1'b0, den_w[s]}) begin
            rem_in = psov_pkg::DEN_W'(cur - {1'b0, den_w[s]});
            quo_in = {quo_w[s][psov_pkg::VOL_W-2:0], 1'b1};
         end else begin
            rem_in = cur[psov_pkg::DEN_W-1:0];
            quo_in = {quo_w[s][psov_pkg::VOL_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff <= 1'b0;
         end else if (adv) begin
            v_ff <= v_w[s];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff <= rem_in;
            quo_ff <= quo_in;
            low_ff <= low_w[s] << 1;
            den_ff <= den_w[s];
            sat_ff <= sat_w[s];
            hit_ff <= hit_w[s];
         end
      end

      assign v_w[s+1]   = v_ff;
      assign rem_w[s+1] = rem_ff;
      assign quo_w[s+1] = quo_ff;
      assign low_w[s+1] = low_ff;
      assign den_w[s+1] = den_ff;
      assign sat_w[s+1] = sat_ff;
      assign hit_w[s+1] = hit_ff;
   end

   always_comb begin
      out_data.overlapped = hit_w[psov_pkg::VOL_W];
      if (!hit_w[psov_pkg::VOL_W]) begin
         out_data.shared_volume = '0;
      end else if (sat_w[psov_pkg::VOL_W]) begin
         out_data.shared_volume = '1;
      end else begin
         out_data.shared_volume = quo_w[psov_pkg::VOL_W];
      end
   end

   assign out_valid = v_w[psov_pkg::VOL_W];

endmodule

/* rtl/core/periodic_sphere_overlap_volume.sv */
// Register path from the accepted request to rsp_valid, 64 register stages in all:
//   geometry 3, square root 19, volume products 7, divider 34, output 1.
// One transaction per cycle unless stalled; the per-bit root and divider stages set depth.
// A held response stalls the pipe only when its last stage holds a result.
// Reset clears every valid bit and loads the box sizes with 64 and the margin with 1.
// ----------------------------------------------------------------------------
// periodic_sphere_overlap_volume
// Overlap flag and shared volume of two spheres in a periodic box.
// ----------------------------------------------------------------------------
module periodic_sphere_overlap_volume (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  psov_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output psov_pkg::rsp_type               rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [psov_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [psov_pkg::CSR_DATA_W-1:0] csr_data
);

   logic [psov_pkg::BOX_W-1:0]    box_x_ff, box_y_ff, box_z_ff;
   logic [psov_pkg::MARGIN_W-1:0] margin_ff;

   logic                          adv;
   logic                          geom_valid, sqrt_valid, vol_valid, div_valid;
   psov_pkg::root_in_type         geom_data;
   logic [psov_pkg::ROOT_W-1:0]   sqrt_root;
   psov_pkg::side_type            sqrt_side;
   psov_pkg::quo_type             vol_data;
   psov_pkg::rsp_type             div_data;

   logic                          rsp_valid_ff, rsp_valid_in;
   psov_pkg::rsp_type             rsp_data_ff;

   // advance unless a finished result would land on a held response
   assign adv       = !div_valid || !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         box_x_ff  <= psov_pkg::BOX_RESET;
         box_y_ff  <= psov_pkg::BOX_RESET;
         box_z_ff  <= psov_pkg::BOX_RESET;
         margin_ff <= psov_pkg::MARGIN_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            psov_pkg::CSR_BOX_X:  box_x_ff  <= csr_data[psov_pkg::BOX_W-1:0];
            psov_pkg::CSR_BOX_Y:  box_y_ff  <= csr_data[psov_pkg::BOX_W-1:0];
            psov_pkg::CSR_BOX_Z:  box_z_ff  <= csr_data[psov_pkg::BOX_W-1:0];
            psov_pkg::CSR_MARGIN: margin_ff <= csr_data[psov_pkg::MARGIN_W-1:0];
            default: ;
         endcase
      end
   end

   psov_geom u_geom (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .box_x     (box_x_ff),
      .box_y     (box_y_ff),
      .box_z     (box_z_ff),
      .margin    (margin_ff),
      .out_valid (geom_valid),
      .out_data  (geom_data)
   );

   psov_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (geom_valid),
      .in_data   (geom_data),
      .out_valid (sqrt_valid),
      .out_root  (sqrt_root),
      .out_side  (sqrt_side)
   );

   psov_vol u_vol (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (sqrt_valid),
      .in_root   (sqrt_root),
      .in_side   (sqrt_side),
      .out_valid (vol_valid),
      .out_data  (vol_data)
   );

   psov_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (vol_valid),
      .in_data   (vol_data),
      .out_valid (div_valid),
      .out_data  (div_data)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (div_valid) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (div_valid && adv) begin
         rsp_data_ff <= div_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_no_volume_without_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.overlapped |-> rsp_data.shared_volume == '0)
      else $error("volume reported without overlap");

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready && div_valid |-> !req_ready)
      else $error("input taken while a finished result is blocked");

   a_reset_clears_output: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   a_margin_write: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_index == psov_pkg::CSR_MARGIN
      |=> margin_ff == $past(csr_data[psov_pkg::MARGIN_W-1:0]))
      else $error("margin register not updated");
`endif

endmodule

/* verif/psov_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// psov_checker
// Watches the request, response and register ports of the sphere overlap
// pipeline, predicts the overlap flag and shared volume of every accepted
// pair and compares each response with the oldest prediction in order.
// ----------------------------------------------------------------------------
module psov_checker
   import psov_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  req_type               req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  rsp_type               rsp_data,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output int                    failures,
   output int                    pending,
   output int                    overlaps_seen
);

   localparam logic [127:0]     PI_WIDE = 128'(PI_Q30);
   localparam logic [VOL_W-1:0] VOL_MAX = '1;

   logic [BOX_W-1:0]    box_x, box_y, box_z;
   logic [MARGIN_W-1:0] margin;
   rsp_type             volume_queue[$];

   initial begin
      failures      = 0;
      overlaps_seen = 0;
      pending       = 0;
   end

   function automatic logic [63:0] floor_root(logic [63:0] v);
      logic [63:0] r;
      logic [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // minimum-image offset on one axis, squared
   function automatic logic [63:0] axis_square(logic [63:0] a, logic [63:0] b,
                                               logic [BOX_W-1:0] box);
      logic [63:0] len, ad, w, m;
      len = 64'(box) << FRAC_BITS;
      ad  = (a > b) ? a - b : b - a;
      w   = (len > ad) ? len - ad : ad - len;
      m   = (ad < w) ? ad : w;
      return m * m;
   endfunction

   function automatic logic [VOL_W-1:0] scale_volume(logic [127:0] q);
      logic [127:0] s;
      s = q >> (2 * FRAC_BITS + 30);
      return (s > 128'(VOL_MAX)) ? VOL_MAX : s[VOL_W-1:0];
   endfunction

   function automatic rsp_type predict_overlap(req_type p);
      logic [63:0]  dist2, r1, r2, rs, rdif, rmin, d, a, pos, neg, b;
      logic [127:0] num;
      rsp_type      res;
      r1    = 64'(p.first_radius);
      r2    = 64'(p.second_radius);
      dist2 = axis_square(64'(p.first_x), 64'(p.second_x), box_x)
            + axis_square(64'(p.first_y), 64'(p.second_y), box_y)
            + axis_square(64'(p.first_z), 64'(p.second_z), box_z);
      rs    = r1 + r2;
      rdif  = (r1 > r2) ? r1 - r2 : r2 - r1;
      rmin  = (r1 < r2) ? r1 : r2;
      res.overlapped    = (rs * rs > dist2 + 64'(margin));
      res.shared_volume = '0;
      if (res.overlapped) begin
         d = floor_root(dist2);
         if (dist2 <= rdif * rdif || d == 0) begin
            // one sphere inside the other, or a zero root distance: smaller sphere volume
            num = 128'(rmin) * 128'(rmin) * 128'(rmin) * 128'd4 * PI_WIDE;
            res.shared_volume = scale_volume(num / 128'd3);
         end else begin
            a   = (rs > d) ? rs - d : 0;
            pos = d * d + 2 * d * rs;
            neg = 3 * rdif * rdif;
            b   = (pos > neg) ? pos - neg : 0;
            num = 128'(a) * 128'(a) * 128'(b) * PI_WIDE;
            res.shared_volume = scale_volume(num / (128'd12 * 128'(d)));
         end
      end
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
      failures = failures + 1;
      $display("%0t mismatch %s: expected %0d, got %0d", $realtime, what, want, got);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         box_x  <= BOX_RESET;
         box_y  <= BOX_RESET;
         box_z  <= BOX_RESET;
         margin <= MARGIN_RESET;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_BOX_X:  box_x  <= csr_data[BOX_W-1:0];
               CSR_BOX_Y:  box_y  <= csr_data[BOX_W-1:0];
               CSR_BOX_Z:  box_z  <= csr_data[BOX_W-1:0];
               CSR_MARGIN: margin <= csr_data;
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            volume_queue = {volume_queue, predict_overlap(req_data)};
         if (rsp_valid && rsp_ready) begin
            if (volume_queue.size() == 0) begin
               report_mismatch("unexpected response", 0, 1);
            end else begin
               want = volume_queue.pop_front();
               if (rsp_data.overlapped) overlaps_seen = overlaps_seen + 1;
               if (rsp_data.overlapped !== want.overlapped)
                  report_mismatch("overlapped", 64'(want.overlapped),
                                  64'(rsp_data.overlapped));
               if (rsp_data.shared_volume !== want.shared_volume)
                  report_mismatch("shared_volume", 64'(want.shared_volume),
                                  64'(rsp_data.shared_volume));
            end
         end
      end
      pending = volume_queue.size();
   end

endmodule

/* verif/periodic_sphere_overlap_volume_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// periodic_sphere_overlap_volume_tb
// Drives sphere pairs through the overlap volume pipeline under several box
// and margin settings, with random gaps and stalls on both channels and one
// long response stall; the checker predicts and compares every response.
// ----------------------------------------------------------------------------
module periodic_sphere_overlap_volume_tb;
   import psov_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 4'd9;
   localparam int RANDOM_PER_PHASE = 408;
   localparam int DRAIN_CYCLES     = 120;

   logic                  clock = 0;
   logic                  reset = 1;
   logic                  req_valid = 0;
   logic                  req_ready;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 0;
   rsp_type               rsp_data;
   logic                  csr_valid = 0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;
   int                    failures, pending, overlaps_seen;

   int   tx_idle_pct = 0;
   int   rx_idle_pct = 0;
   logic stall_arm = 0;
   logic stall_seen = 0;
   int   stall_left = 0;
   int   pairs_sent = 0;
   int   settings_run = 0;
   logic [BOX_W-1:0] cur_box[3];

   always #10 clock = ~clock;

   periodic_sphere_overlap_volume u_dut (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data,
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   psov_checker u_checker (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data,
      .csr_valid, .csr_ready, .csr_index, .csr_data,
      .failures, .pending, .overlaps_seen
   );

   // receiver: random stalls, plus a long hold-off when the stimulus toggles stall_arm
   always @(posedge clock) begin
      if (stall_arm != stall_seen) begin
         stall_seen <= stall_arm;
         stall_left <= 400;
         rsp_ready  <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   initial begin
      #4_000_000;
      $display("timeout with %0d responses outstanding", pending);
      $display("== FAIL ==");
      $finish;
   end

   task automatic send_pair(req_type p);
      logic rdy;
      if ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 0;
         do @(posedge clock); while ($urandom_range(99) < tx_idle_pct);
      end
      req_valid <= 1;
      req_data  <= p;
      do begin
         @(negedge clock) rdy = req_ready;
         @(posedge clock);
      end while (!rdy);
      pairs_sent++;
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      logic rdy;
      csr_valid <= 1;
      csr_index <= idx;
      csr_data  <= val;
      do begin
         @(negedge clock) rdy = csr_ready;
         @(posedge clock);
      end while (!rdy);
      csr_valid <= 0;
      if (idx == CSR_BOX_X) cur_box[0] = val[BOX_W-1:0];
      if (idx == CSR_BOX_Y) cur_box[1] = val[BOX_W-1:0];
      if (idx == CSR_BOX_Z) cur_box[2] = val[BOX_W-1:0];
   endtask

   task automatic drain;
      req_valid <= 0;
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_geometry(int bx, int by, int bz, int mg);
      write_reg(CSR_BOX_X, 16'(bx));
      write_reg(CSR_BOX_Y, 16'(by));
      write_reg(CSR_BOX_Z, 16'(bz));
      write_reg(CSR_MARGIN, 16'(mg));
      settings_run++;
   endtask

   function automatic logic [COORD_W-1:0] coord_in_box(int axis);
      int len;
      len = int'(cur_box[axis]) << FRAC_BITS;
      if (len == 0 || $urandom_range(9) == 0) return COORD_W'($urandom);
      return COORD_W'($urandom_range(len - 1));
   endfunction

   function automatic logic [COORD_W-1:0] coord_near(logic [COORD_W-1:0] c, int axis,
                                                     int spread);
      int len, v;
      len = int'(cur_box[axis]) << FRAC_BITS;
      v = int'(c) + $urandom_range(2 * spread) - spread;
      if (len > 0) begin
         while (v < 0) v += len;
         while (v >= len) v -= len;
      end else if (v < 0) begin
         v = 0;
      end
      return COORD_W'(v);
   endfunction

   function automatic logic [RAD_W-1:0] random_radius();
      return RAD_W'($urandom_range((1 << $urandom_range(RAD_W, 6)) - 1));
   endfunction

   function automatic req_type make_pair();
      req_type p;
      int      spread;
      p.first_radius  = random_radius();
      p.second_radius = random_radius();
      p.first_x = coord_in_box(0);
      p.first_y = coord_in_box(1);
      p.first_z = coord_in_box(2);
      if ($urandom_range(9) < 7) begin
         // neighbors within reach of the radii, across the box edge at times
         spread = int'(p.first_radius) + int'(p.second_radius) + 1;
         p.second_x = coord_near(p.first_x, 0, spread);
         p.second_y = coord_near(p.first_y, 1, spread);
         p.second_z = coord_near(p.first_z, 2, spread);
      end else begin
         p.second_x = coord_in_box(0);
         p.second_y = coord_in_box(1);
         p.second_z = coord_in_box(2);
      end
      return p;
   endfunction

   function automatic req_type pair_of(int x1, int y1, int z1, int r1,
                                       int x2, int y2, int z2, int r2);
      req_type p;
      p = '{COORD_W'(x1), COORD_W'(y1), COORD_W'(z1), RAD_W'(r1),
            COORD_W'(x2), COORD_W'(y2), COORD_W'(z2), RAD_W'(r2)};
      return p;
   endfunction

   task automatic random_phase(int count);
      for (int i = 0; i < count; i++) begin
         if (i < count / 3) begin
            tx_idle_pct = 25; rx_idle_pct = 70;
         end else if (i < 2 * count / 3) begin
            tx_idle_pct = 70; rx_idle_pct = 25;
         end else begin
            tx_idle_pct = 0;  rx_idle_pct = 0;
         end
         send_pair(make_pair());
      end
      drain();
   endtask

   initial begin
      int one, top_c, top_r;
      one   = 1 << FRAC_BITS;
      top_c = (1 << COORD_W) - 1;
      top_r = (1 << RAD_W) - 1;
      cur_box = '{BOX_RESET, BOX_RESET, BOX_RESET};
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed pairs under reset settings
      send_pair(pair_of(0, 0, 0, 0, 0, 0, 0, 0));
      send_pair(pair_of(5*one, 5*one, 5*one, one, 5*one, 5*one, 5*one, one));
      send_pair(pair_of(9*one, 9*one, 9*one, top_r, 9*one, 9*one, 9*one, top_r));
      send_pair(pair_of(9*one, 9*one, 9*one, top_r, 12*one, 9*one, 9*one, 2*one));
      send_pair(pair_of(9*one, 9*one, 9*one, 0, 9*one, 9*one, 9*one, 3*one));
      send_pair(pair_of(9*one, 9*one, 9*one, 2*one, 11*one, 9*one, 9*one, 2*one));
      send_pair(pair_of(9*one, 9*one, 9*one, one, 11*one, 9*one, 9*one, one));
      send_pair(pair_of(9*one, 9*one, 9*one, one, 40*one, 9*one, 9*one, one));
      send_pair(pair_of(one/8, 2*one, 2*one, one, 63*one, 2*one, 2*one, one));
      send_pair(pair_of(2*one, one/4, one/2, 3*one, 2*one, 63*one, 63*one, 3*one));
      send_pair(pair_of(top_c, top_c, top_c, top_r, 0, 0, 0, top_r));
      send_pair(pair_of(top_c, top_c, top_c, 5, top_c, top_c, top_c, top_r));
      send_pair(pair_of(0, 0, 0, top_r, top_c, top_c, top_c, 0));
      send_pair(pair_of(30*one, 30*one, 30*one, 20*one, 31*one, 30*one, 30*one, 20*one));
      send_pair(pair_of(1, 0, 0, 1, 0, 0, 0, 1));
      send_pair(pair_of(3*one, 3*one, 3*one, top_r, 3*one + 1, 3*one, 3*one, top_r - 1));

      // long response stall so the pipe fills and backs up the requests
      stall_arm <= ~stall_arm;
      for (int i = 0; i < 100; i++) send_pair(make_pair());
      drain();

      random_phase(RANDOM_PER_PHASE);

      // ignored index must leave settings untouched
      write_reg(CSR_UNUSED, 16'hFFFF);
      set_geometry(1, 1, 1, 0);
      send_pair(pair_of(0, 0, 0, top_r, one - 1, one - 1, one - 1, top_r));
      random_phase(RANDOM_PER_PHASE);

      set_geometry(1023, 1023, 1023, 65535);
      send_pair(pair_of(0, 0, 0, top_r, top_c, top_c, top_c, top_r));
      random_phase(RANDOM_PER_PHASE);

      // zero box length: raw difference on that axis
      set_geometry(0, 17, 300, $urandom_range(65535));
      random_phase(RANDOM_PER_PHASE / 2);
      set_geometry($urandom_range(1023, 1), $urandom_range(1023, 1),
                   $urandom_range(1023, 1), $urandom_range(255));
      random_phase(RANDOM_PER_PHASE / 2);

      $display("%0d sphere pairs under %0d box/margin settings beyond reset, %0d overlapping",
               pairs_sent, settings_run, overlaps_seen);
      $display("gaps and stalls on both channels, one long response hold-off");
      if (failures == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches", failures);
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
